### hdl/led_candle_breath_effect_engine_top_macros.svh
// Assertion macros used by the effect engine RTL.
`ifndef LED_CANDLE_BREATH_EFFECT_ENGINE_TOP_MACROS_SVH
`define LED_CANDLE_BREATH_EFFECT_ENGINE_TOP_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define LCBE_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a trigger implies a condition in the following cycle.
`define LCBE_ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

### hdl/lcbe_pkg.sv
// Shared types and constants of the candle and breathing effect engine.
package lcbe_pkg;

  localparam int TIME_BITS      = 32;
  localparam int TIME_MS_BITS   = 32;
  localparam int MIC_BITS       = 10;
  localparam int BOOST_BITS     = 8;
  localparam int LEVEL_BITS     = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_BREATH = 2'd1,
    MODE_CANDLE = 2'd2,
    MODE_ADC    = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE              = 3'd0,
    REG_FLICKER_INTERVAL  = 3'd1,
    REG_FLICKER_INTENSITY = 3'd2,
    REG_LEVEL_FLOOR       = 3'd3,
    REG_TIP_BASE          = 3'd4,
    REG_UPPER_BASE        = 3'd5,
    REG_MIDDLE_BASE       = 3'd6,
    REG_BOTTOM_BASE       = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] FLICKER_INTERVAL_RESET  = 16'd50;
  localparam logic [7:0]  FLICKER_INTENSITY_RESET = 8'd100;
  localparam logic [7:0]  LEVEL_FLOOR_RESET       = 8'd5;
  localparam logic [7:0]  TIP_BASE_RESET          = 8'd120;
  localparam logic [7:0]  UPPER_BASE_RESET        = 8'd90;
  localparam logic [7:0]  MIDDLE_BASE_RESET       = 8'd60;
  localparam logic [7:0]  BOTTOM_BASE_RESET       = 8'd40;
  localparam logic [7:0]  SEED_RESET              = 8'd42;

endpackage

### hdl/lcbe_tick_if.sv
// Tick input channel: one tick per transaction under a valid/ready handshake.
interface lcbe_tick_if;
  import lcbe_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [TIME_MS_BITS-1:0] time_ms;
  logic [MIC_BITS-1:0]     mic_level;
  logic [BOOST_BITS-1:0]   intensity_boost;
  logic                    song_playing;

  modport source (
    output valid, time_ms, mic_level, intensity_boost, song_playing,
    input  ready
  );

  modport sink (
    input  valid, time_ms, mic_level, intensity_boost, song_playing,
    output ready
  );
endinterface

### hdl/lcbe_ring_if.sv
// Ring level output channel: four ring levels per transaction.
interface lcbe_ring_if;
  import lcbe_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] tip_level;
  logic [LEVEL_BITS-1:0] upper_level;
  logic [LEVEL_BITS-1:0] middle_level;
  logic [LEVEL_BITS-1:0] bottom_level;

  modport source (
    output valid, tip_level, upper_level, middle_level, bottom_level,
    input  ready
  );

  modport sink (
    input  valid, tip_level, upper_level, middle_level, bottom_level,
    output ready
  );
endinterface

### hdl/lcbe_cfg_if.sv
// Configuration write channel: register index and data per transaction.
interface lcbe_cfg_if;
  import lcbe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

### hdl/led_candle_breath_effect_engine_top.sv
// Top level of the candle and breathing LED effect engine.
//
//   channel | dir | transaction
//   --------+-----+----------------------------------------------------------
//   cfg     | in  | register index and data, always ready
//   tick    | in  | time_ms, mic_level, intensity_boost, song_playing
//   ring    | out | tip_level, upper_level, middle_level, bottom_level
//
// One tick per cycle sustained while the ring channel accepts results; a tick passes through
// the five-register pipeline: input, state update, products,
// reciprocal quotients, ring sum and clamp in the output register that drives ring.
// Synchronous rst clears all valid bits and resets the effect state and config registers.
// A stalled ring channel holds its result; the stages behind it keep filling and
// tick.ready drops only once all of them hold a transaction.
// Ticks during a song or in off mode, and candle ticks between updates, give no result.
`include "led_candle_breath_effect_engine_top_macros.svh"

module led_candle_breath_effect_engine_top (
  input  logic        clk,
  input  logic        rst,
  lcbe_cfg_if.sink    cfg,
  lcbe_tick_if.sink   tick,
  lcbe_ring_if.source ring
);
  import lcbe_pkg::*;

  typedef struct packed {
    mode_t           kind;
    logic [7:0]      breath_level;
    logic [3:0]      adc_hit;
    logic [3:0][8:0] adc_diff;
    logic [3:0][6:0] fd;
    logic [3:0][6:0] md;
    logic [6:0]      gd;
    logic            gust;
    logic [6:0]      boost;
  } st1_t;

  typedef struct packed {
    mode_t            kind;
    logic [7:0]       breath_level;
    logic [3:0]       adc_hit;
    logic [3:0][16:0] adc_prod;
    logic [3:0]       fd_neg;
    logic [3:0][13:0] fd_prod;
    logic [3:0]       md_neg;
    logic [3:0][13:0] md_prod;
    logic             gd_neg;
    logic [13:0]      gd_prod;
    logic             gust;
    logic [3:0][12:0] gust_prod;
    logic [3:0][9:0]  boost_prod;
  } st2_t;

  typedef struct packed {
    mode_t           kind;
    logic [7:0]      breath_level;
    logic [3:0]      adc_hit;
    logic [3:0][7:0] adc_q;
    logic [3:0]      fd_neg;
    logic [3:0][7:0] fd_q;
    logic [3:0]      md_neg;
    logic [3:0][7:0] md_q;
    logic            gd_neg;
    logic [3:0][7:0] gd_q;
    logic            gust;
    logic [3:0][7:0] gust_q;
    logic [3:0][7:0] boost_q;
  } st3_t;

  localparam logic [3:0][9:0]  ADC_THR     = {10'd50, 10'd150, 10'd250, 10'd400};
  localparam logic [3:0][18:0] ADC_RECIP   = {19'd131587, 19'd163681, 19'd216481,
                                              19'd419431};
  localparam logic [4:0]       ADC_SHIFT   = 5'd26;
  localparam logic [18:0]      PCT_RECIP   = 19'd5243;
  localparam logic [4:0]       PCT_SHIFT   = 5'd19;
  localparam logic [3:0][18:0] GSW_RECIP   = {19'd6991, 19'd5243, 19'd6991, 19'd5243};
  localparam logic [3:0][4:0]  GSW_SHIFT   = {5'd22, 5'd21, 5'd21, 5'd20};
  localparam logic [3:0][4:0]  GUST_PCT    = {5'd12, 5'd20, 5'd25, 5'd30};
  localparam logic [3:0][2:0]  BOOST_MUL   = {3'd2, 3'd3, 3'd7, 3'd4};
  localparam logic [18:0]      BOOST_RECIP = 19'd205;
  localparam logic [3:0][4:0]  BOOST_SHIFT = {5'd10, 5'd10, 5'd11, 5'd10};
  localparam logic [3:0][7:0]  RING_CEIL   = {8'd70, 8'd100, 8'd140, 8'd180};

  function automatic logic [7:0] recip_div(input logic [16:0] n, input logic [18:0] m,
                                           input logic [4:0] k);
    logic [35:0] p;
    p = 36'(n) * 36'(m);
    return 8'(p >> k);
  endfunction

  function automatic logic signed [10:0] signed_term(input logic neg, input logic [7:0] q);
    logic signed [10:0] t;
    t = $signed({3'b000, q});
    return neg ? -t : t;
  endfunction

  function automatic logic [7:0] clamp_ring(input logic signed [10:0] v,
                                            input logic [7:0] floor_lvl,
                                            input logic [7:0] ceil_lvl);
    logic signed [10:0] t;
    t = v;
    if (t < $signed({3'b000, floor_lvl})) t = $signed({3'b000, floor_lvl});
    if (t > $signed({3'b000, ceil_lvl})) t = $signed({3'b000, ceil_lvl});
    return t[7:0];
  endfunction

  mode_t       mode;
  logic [15:0] flicker_interval_ms;
  logic [7:0]  flicker_intensity;
  logic [7:0]  level_floor;
  logic [7:0]  tip_base;
  logic [7:0]  upper_base;
  logic [7:0]  middle_base;
  logic [7:0]  bottom_base;

  logic [15:0]          effect_count;
  logic [14:0]          effect_div3;
  logic [1:0]           effect_mod3;
  logic [7:0]           breath_offset;
  logic                 breath_rising;
  logic [TIME_BITS-1:0] breath_last_ms;
  logic [TIME_BITS-1:0] candle_last_ms;
  logic [7:0]           flicker_seed;

  logic                 v0, v1, v2, v3, v4;
  logic                 en0, en1, en2, en3, en4;
  logic                 take1;
  logic                 cfg_wr;
  logic [TIME_BITS-1:0] s0_now;
  logic [9:0]           s0_adc;
  logic [6:0]           s0_boost;
  st1_t                 st1, st1_next;
  st2_t                 st2, st2_next;
  st3_t                 st3, st3_next;
  logic [3:0][7:0]      level, level_next;
  logic [3:0][7:0]      base_lvl;

  logic [15:0]          cnt_next;
  logic [14:0]          div3_next;
  logic [1:0]           mod3_next;
  logic [TIME_BITS-1:0] breath_diff, candle_diff;
  logic                 breath_due, candle_due;
  logic [7:0]           offset_up, offset_next;
  logic                 rising_next;
  logic [7:0]           seed_next;
  logic [7:0]           seed_t0, seed_t1, seed_t2, seed_t3;
  logic [5:0]           fast0;
  logic [4:0]           fast1;
  logic [3:0]           fast2;
  logic [2:0]           fast3;
  logic [6:0]           gx;
  logic [5:0]           gsw;
  logic [4:0]           mx0, mx1;
  logic [3:0]           mx2;
  logic [2:0]           mx3;
  logic [3:0]           med0, med1;
  logic [2:0]           med2;
  logic [1:0]           med3;
  logic signed [6:0]    mt0, mt1, mt2, mt3, ft3;
  logic [9:0]           adc_sat;
  logic [9:0]           adc_sub;
  logic [6:0]           abs_fd, abs_md, abs_gd;
  logic signed [10:0]   ring_sum;

  assign cfg.ready  = 1'b1;
  assign cfg_wr     = cfg.valid & cfg.ready;

  assign en4        = !v4 || ring.ready;
  assign en3        = !v3 || en4;
  assign en2        = !v2 || en3;
  assign en1        = !v1 || en2;
  assign en0        = !v0 || en1;
  assign take1      = v0 && en1;
  assign tick.ready = en0;

  assign base_lvl   = {bottom_base, middle_base, upper_base, tip_base};

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= tick.valid && !tick.song_playing && (mode != MODE_OFF);
    end
    if (en0 && tick.valid) begin
      s0_now   <= tick.time_ms[TIME_BITS-1:0];
      s0_adc   <= tick.mic_level;
      s0_boost <= (tick.intensity_boost > 8'd100) ? 7'd100 : tick.intensity_boost[6:0];
    end
  end

  // State update and term forming
  always_comb begin
    cnt_next = effect_count + 16'd1;
    if (cnt_next == 16'd0) begin
      div3_next = 15'd0;
      mod3_next = 2'd0;
    end else if (effect_mod3 == 2'd2) begin
      div3_next = effect_div3 + 15'd1;
      mod3_next = 2'd0;
    end else begin
      div3_next = effect_div3;
      mod3_next = effect_mod3 + 2'd1;
    end

    breath_diff = s0_now - breath_last_ms;
    breath_due  = breath_diff >= TIME_BITS'(100);
    offset_up   = breath_offset + 8'd10;
    offset_next = breath_offset;
    rising_next = breath_rising;
    if (breath_due) begin
      if (breath_rising) begin
        if (offset_up >= 8'd205) begin
          offset_next = 8'd205;
          rising_next = 1'b0;
        end else begin
          offset_next = offset_up;
        end
      end else if (breath_offset >= 8'd10) begin
        offset_next = breath_offset - 8'd10;
      end else begin
        offset_next = 8'd0;
        rising_next = 1'b1;
      end
    end

    candle_diff = s0_now - candle_last_ms;
    candle_due  = candle_diff >= TIME_BITS'(flicker_interval_ms);
    seed_next   = flicker_seed * 8'd13 + 8'd37;
    seed_t0     = seed_next + 8'd7;
    seed_t1     = seed_next + 8'd13;
    seed_t2     = seed_next + 8'd19;
    seed_t3     = seed_next + 8'd23;
    fast0       = seed_t0[5:0] * 6'd5;
    fast1       = seed_t1[4:0] * 5'd3;
    fast2       = {seed_t2[2:0], 1'b0};
    fast3       = seed_t3[2:0];

    gx   = cnt_next[9:3];
    gsw  = (gx > 7'd63) ? 6'(7'd127 - gx) : gx[5:0];
    mx0  = cnt_next[4:0] + 5'd3;
    mx1  = cnt_next[5:1] + 5'd7;
    mx2  = div3_next[3:0] + 4'd11;
    mx3  = div3_next[3:1];
    med0 = (mx0 > 5'd15) ? 4'(5'd31 - mx0) : mx0[3:0];
    med1 = (mx1 > 5'd15) ? 4'(5'd31 - mx1) : mx1[3:0];
    med2 = (mx2 > 4'd7) ? 3'(4'd15 - mx2) : mx2[2:0];
    med3 = (mx3 > 3'd3) ? 2'(3'd7 - mx3) : mx3[1:0];

    mt0 = $signed({3'b000, med0}) - 7'sd7;
    mt1 = $signed({3'b000, med1}) - 7'sd7;
    mt2 = $signed({4'b0000, med2}) - 7'sd3;
    mt3 = $signed({5'b00000, med3}) - 7'sd1;
    ft3 = $signed({4'b0000, fast3}) - 7'sd3;

    st1_next.kind         = mode;
    st1_next.breath_level = 8'd50 + offset_next;
    st1_next.fd[0]        = $signed({1'b0, fast0}) - 7'sd31;
    st1_next.fd[1]        = $signed({2'b00, fast1}) - 7'sd15;
    st1_next.fd[2]        = $signed({3'b000, fast2}) - 7'sd7;
    st1_next.fd[3]        = ft3 <<< 1;
    st1_next.md[0]        = mt0 + (mt0 <<< 1);
    st1_next.md[1]        = mt1 <<< 1;
    st1_next.md[2]        = mt2 <<< 1;
    st1_next.md[3]        = mt3 <<< 1;
    st1_next.gd           = $signed({1'b0, gsw}) - 7'sd31;
    st1_next.gust         = seed_next[4:0] == 5'h1F;
    st1_next.boost        = s0_boost;

    adc_sat = (s0_adc > 10'd560) ? 10'd560 : s0_adc;
    for (int i = 0; i < 4; i++) begin
      adc_sub              = adc_sat - ADC_THR[i];
      st1_next.adc_hit[i]  = s0_adc > ADC_THR[i];
      st1_next.adc_diff[i] = adc_sub[8:0];
    end
  end

  // Configuration and effect state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_OFF;
      flicker_interval_ms <= FLICKER_INTERVAL_RESET;
      flicker_intensity   <= FLICKER_INTENSITY_RESET;
      level_floor         <= LEVEL_FLOOR_RESET;
      tip_base            <= TIP_BASE_RESET;
      upper_base          <= UPPER_BASE_RESET;
      middle_base         <= MIDDLE_BASE_RESET;
      bottom_base         <= BOTTOM_BASE_RESET;
      effect_count        <= 16'd0;
      effect_div3         <= 15'd0;
      effect_mod3         <= 2'd0;
      breath_offset       <= 8'd0;
      breath_rising       <= 1'b1;
      breath_last_ms      <= '0;
      candle_last_ms      <= '0;
      flicker_seed        <= SEED_RESET;
    end else begin
      if (take1) begin
        effect_count <= cnt_next;
        effect_div3  <= div3_next;
        effect_mod3  <= mod3_next;
        if (mode == MODE_BREATH && breath_due) begin
          breath_offset  <= offset_next;
          breath_rising  <= rising_next;
          breath_last_ms <= s0_now;
        end
        if (mode == MODE_CANDLE && candle_due) begin
          candle_last_ms <= s0_now;
          flicker_seed   <= seed_next;
        end
      end
      if (cfg_wr) begin
        case (cfg_reg_t'(cfg.index))
          REG_MODE: begin
            mode         <= mode_t'(cfg.data[1:0]);
            effect_count <= 16'd0;
            effect_div3  <= 15'd0;
            effect_mod3  <= 2'd0;
          end
          REG_FLICKER_INTERVAL:  flicker_interval_ms <= cfg.data;
          REG_FLICKER_INTENSITY: flicker_intensity   <= cfg.data[7:0];
          REG_LEVEL_FLOOR:       level_floor         <= cfg.data[7:0];
          REG_TIP_BASE:          tip_base            <= cfg.data[7:0];
          REG_UPPER_BASE:        upper_base          <= cfg.data[7:0];
          REG_MIDDLE_BASE:       middle_base         <= cfg.data[7:0];
          REG_BOTTOM_BASE:       bottom_base         <= cfg.data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0 && (mode != MODE_CANDLE || candle_due);
    end
    if (en1) begin
      st1 <= st1_next;
    end
  end

  // Products
  always_comb begin
    st2_next.kind         = st1.kind;
    st2_next.breath_level = st1.breath_level;
    st2_next.adc_hit      = st1.adc_hit;
    st2_next.gust         = st1.gust;
    st2_next.gd_neg       = st1.gd[6];
    abs_gd                = st1.gd[6] ? 7'(-st1.gd) : st1.gd;
    st2_next.gd_prod      = 14'(abs_gd) * 14'(flicker_intensity);
    abs_fd                = 7'd0;
    abs_md                = 7'd0;
    for (int i = 0; i < 4; i++) begin
      st2_next.adc_prod[i]   = 17'(st1.adc_diff[i]) * 17'd250;
      st2_next.fd_neg[i]     = st1.fd[i][6];
      abs_fd                 = st1.fd[i][6] ? 7'(-st1.fd[i]) : st1.fd[i];
      st2_next.fd_prod[i]    = 14'(abs_fd) * 14'(flicker_intensity);
      st2_next.md_neg[i]     = st1.md[i][6];
      abs_md                 = st1.md[i][6] ? 7'(-st1.md[i]) : st1.md[i];
      st2_next.md_prod[i]    = 14'(abs_md) * 14'(flicker_intensity);
      st2_next.gust_prod[i]  = 13'(flicker_intensity) * 13'(GUST_PCT[i]);
      st2_next.boost_prod[i] = 10'(st1.boost) * 10'(BOOST_MUL[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      st2 <= st2_next;
    end
  end

  // Quotients by reciprocal multiplication
  always_comb begin
    st3_next.kind         = st2.kind;
    st3_next.breath_level = st2.breath_level;
    st3_next.adc_hit      = st2.adc_hit;
    st3_next.fd_neg       = st2.fd_neg;
    st3_next.md_neg       = st2.md_neg;
    st3_next.gd_neg       = st2.gd_neg;
    st3_next.gust         = st2.gust;
    for (int i = 0; i < 4; i++) begin
      st3_next.adc_q[i]   = recip_div(st2.adc_prod[i], ADC_RECIP[i], ADC_SHIFT);
      st3_next.fd_q[i]    = recip_div(17'(st2.fd_prod[i]), PCT_RECIP, PCT_SHIFT);
      st3_next.md_q[i]    = recip_div(17'(st2.md_prod[i]), PCT_RECIP, PCT_SHIFT);
      st3_next.gd_q[i]    = recip_div(17'(st2.gd_prod), GSW_RECIP[i], GSW_SHIFT[i]);
      st3_next.gust_q[i]  = recip_div(17'(st2.gust_prod[i]), PCT_RECIP, PCT_SHIFT);
      st3_next.boost_q[i] = recip_div(17'(st2.boost_prod[i]), BOOST_RECIP,
                                      BOOST_SHIFT[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      st3 <= st3_next;
    end
  end

  // Ring sum, clamp and effect select
  always_comb begin
    ring_sum = '0;
    for (int i = 0; i < 4; i++) begin
      ring_sum = $signed({3'b000, base_lvl[i]})
               + signed_term(st3.fd_neg[i], st3.fd_q[i])
               + signed_term(st3.md_neg[i], st3.md_q[i])
               + signed_term(st3.gd_neg, st3.gd_q[i])
               + signed_term(1'b0, st3.boost_q[i]);
      if (st3.gust) begin
        ring_sum = ring_sum - signed_term(1'b0, st3.gust_q[i]);
      end
      case (st3.kind)
        MODE_BREATH: level_next[i] = st3.breath_level;
        MODE_ADC:    level_next[i] = st3.adc_hit[i] ? st3.adc_q[i] + 8'd5 : 8'd0;
        MODE_CANDLE: level_next[i] = clamp_ring(ring_sum, level_floor, RING_CEIL[i]);
        default:     level_next[i] = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      level <= level_next;
    end
  end

  assign ring.valid        = v4;
  assign ring.tip_level    = level[0];
  assign ring.upper_level  = level[1];
  assign ring.middle_level = level[2];
  assign ring.bottom_level = level[3];

  `LCBE_ASSERT_ALWAYS(a_breath_range, breath_offset <= 8'd205, "breath offset out of range")
  `LCBE_ASSERT_ALWAYS(a_mod3_range, effect_mod3 != 2'd3, "counter remainder out of range")
  `LCBE_ASSERT_ALWAYS(a_div3_match,
      (16'({effect_div3, 1'b0}) + 16'(effect_div3) + 16'(effect_mod3)) == effect_count,
      "counter thirds out of step with counter")
  `LCBE_ASSERT_NEXT(a_state_hold, !take1 && !cfg_wr,
      $stable(effect_count) && $stable(flicker_seed) && $stable(breath_offset),
      "effect state changed without a transaction")

endmodule
